// ===== rtl/glc_pkg.sv =====
package glc_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned KEY_W          = 16;
  localparam int unsigned AGE_W          = 16;
  localparam int unsigned TOTAL_W        = 32;
  localparam int unsigned IDX_OUT_W      = 6;
  localparam int unsigned CFG_W          = 7;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned APB_AW         = 3;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

  // register select is paddr[2]
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last_rd;
    logic is_flush;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/glc_req_if.sv =====
interface glc_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [glc_pkg::KEY_W-1:0]  lookup_key;
  logic                       load_ok;

  modport source (output valid, operation, lookup_key, load_ok, input ready);
  modport sink   (input valid, operation, lookup_key, load_ok, output ready);
endinterface

// ===== rtl/glc_rsp_if.sv =====
interface glc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [glc_pkg::IDX_OUT_W-1:0] slot_index;
  logic                          installed;
  logic                          blank;
  logic [glc_pkg::TOTAL_W-1:0]   hit_total;
  logic [glc_pkg::TOTAL_W-1:0]   miss_total;

  modport source (output valid, hit, slot_index, installed, blank, hit_total, miss_total,
                  input ready);
  modport sink   (input valid, hit, slot_index, installed, blank, hit_total, miss_total,
                  output ready);
endinterface

// ===== rtl/glyph_lru_cache_directory.sv =====
// Fully associative LRU tag directory for glyph lookups.
// Request channel (req_i): operation, lookup_key, load_ok; taken when valid and
// ready are both high. Lookups advance the use clock, search the active slots
// for the key and, on a miss, pick a victim (first empty slot, else the
// oldest by wrapping age, later slot on a tie); flush clears slots, clock and
// counters. Response channel (rsp_o): one response per request, held until
// the receiver takes it.
// Sequence: a lookup is accepted in the idle state, reads the active slots in the
// scan state, evaluates the last word read in the drain state and writes its
// response in the finish state once the output register is free; a flush goes
// from scan straight to finish. One slot is read per cycle from the single-port slot store.
// A new request is taken once the previous one has been written into the
// output register, so a stalled receiver holds at most one finished response
// while the next request is scanned; that request then waits to finish.
// Config: slots_in_use at APB byte address 0, written in the APB access
// phase, readable, reset value 64.
// Reset: asynchronous, active low; all slots empty, clock and counters zero.
module glyph_lru_cache_directory #(
  parameter int unsigned SlotCount = glc_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  glc_req_if.sink                      req_i,
  glc_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [glc_pkg::APB_AW-1:0]   paddr,
  input  logic [glc_pkg::APB_DW-1:0]   pwdata,
  output logic [glc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  logic [glc_pkg::CFG_W-1:0] slots_q;
  logic                      reg_sel;
  glc_pkg::dp_cmd_t          cmd;
  glc_pkg::dp_sts_t          sts;
  logic                      req_ready;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == glc_pkg::REG_SLOTS_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= glc_pkg::SLOTS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      slots_q <= pwdata[glc_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? glc_pkg::APB_DW'(slots_q) : '0;

  assign req_i.ready = req_ready;

  glc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  glc_dpath #(
    .SlotCount (SlotCount)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .slots_in_use_i (slots_q),
    .operation_i    (req_i.operation),
    .lookup_key_i   (req_i.lookup_key),
    .load_ok_i      (req_i.load_ok),
    .rsp_o          (rsp_o)
  );

endmodule

// ===== rtl/glc_ctrl.sv =====
module glc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  glc_pkg::dp_sts_t  sts_i,
  output glc_pkg::dp_cmd_t  cmd_o
);

  glc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      glc_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = glc_pkg::ST_SCAN;
        end
      end
      glc_pkg::ST_SCAN: begin
        if (sts_i.is_flush) begin
          state_d = glc_pkg::ST_FINISH;
        end else begin
          cmd_o.rd = 1'b1;
          if (sts_i.last_rd) begin
            state_d = glc_pkg::ST_DRAIN;
          end
        end
      end
      // last read word is evaluated here
      glc_pkg::ST_DRAIN: begin
        state_d = glc_pkg::ST_FINISH;
      end
      glc_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = glc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = glc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/glc_dpath.sv =====
module glc_dpath #(
  parameter int unsigned SlotCount = glc_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  glc_pkg::dp_cmd_t            cmd_i,
  output glc_pkg::dp_sts_t            sts_o,
  input  logic [glc_pkg::CFG_W-1:0]   slots_in_use_i,
  input  logic                        operation_i,
  input  logic [glc_pkg::KEY_W-1:0]   lookup_key_i,
  input  logic                        load_ok_i,
  glc_rsp_if.source                   rsp_o
);

  localparam int unsigned IdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW  = $clog2(SlotCount + 1);
  localparam int unsigned CmpW  = (CntW > glc_pkg::CFG_W) ? CntW : glc_pkg::CFG_W;
  localparam int unsigned KeyW  = glc_pkg::KEY_W;
  localparam int unsigned AgeW  = glc_pkg::AGE_W;
  localparam int unsigned WordW = KeyW + AgeW;
  localparam int unsigned TotW  = glc_pkg::TOTAL_W;
  localparam int unsigned OutW  = glc_pkg::IDX_OUT_W;

  // slot store: {key, age}; valid bits stand in for the reset clear
  logic [WordW-1:0]     mem [SlotCount];
  logic [SlotCount-1:0] valid_q;

  glc_pkg::op_e   op_q;
  logic [KeyW-1:0] key_q;
  logic            load_ok_q;
  logic [AgeW-1:0] clock_q;
  logic [TotW-1:0] hit_cnt_q, hit_cnt_d;
  logic [TotW-1:0] miss_cnt_q, miss_cnt_d;

  logic [IdxW-1:0]  addr_q;
  logic             rd_vld_q;
  logic [WordW-1:0] rd_word_q;
  logic             rd_valid_bit_q;
  logic [IdxW-1:0]  rd_idx_q;

  logic            hit_found_q, empty_found_q;
  logic [IdxW-1:0] hit_idx_q, empty_idx_q, old_idx_q;
  logic [AgeW-1:0] oldest_q;

  logic            out_valid_q, out_hit_q, out_inst_q, out_blank_q;
  logic [OutW-1:0] out_idx_q;
  logic [TotW-1:0] out_hit_tot_q, out_miss_tot_q;

  logic [CmpW-1:0]  cfg_ext;
  logic [CntW-1:0]  n_act;
  logic [KeyW-1:0]  eff_key;
  logic [AgeW-1:0]  eff_age;
  logic [AgeW-1:0]  age_gap;
  logic [IdxW-1:0]  victim;
  logic             lookup_fin;
  logic             mem_we;
  logic [IdxW-1:0]  wr_idx;
  logic [WordW-1:0] wr_word;

  // active slot count, clamped to 1..SlotCount
  always_comb begin
    cfg_ext = CmpW'(slots_in_use_i);
    if (cfg_ext == '0) begin
      n_act = CntW'(1);
    end else if (cfg_ext > CmpW'(SlotCount)) begin
      n_act = CntW'(SlotCount);
    end else begin
      n_act = CntW'(cfg_ext);
    end
  end

  assign sts_o.last_rd  = (CntW'(addr_q) == (n_act - CntW'(1)));
  assign sts_o.is_flush = (op_q == glc_pkg::OP_FLUSH);
  assign sts_o.out_free = !out_valid_q || rsp_o.ready;

  // evaluation of the word read in the previous cycle
  assign eff_key = rd_valid_bit_q ? rd_word_q[WordW-1:AgeW] : '0;
  assign eff_age = rd_valid_bit_q ? rd_word_q[AgeW-1:0] : '0;
  assign age_gap = clock_q - eff_age;

  assign victim     = empty_found_q ? empty_idx_q : old_idx_q;
  assign lookup_fin = cmd_i.finish && (op_q == glc_pkg::OP_LOOKUP);
  assign mem_we     = lookup_fin && (hit_found_q || load_ok_q);
  assign wr_idx     = hit_found_q ? hit_idx_q : victim;
  assign wr_word    = {key_q, clock_q};

  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (cmd_i.finish) begin
      if (op_q == glc_pkg::OP_FLUSH) begin
        hit_cnt_d  = '0;
        miss_cnt_d = '0;
      end else if (hit_found_q) begin
        hit_cnt_d = hit_cnt_q + TotW'(1);
      end else begin
        miss_cnt_d = miss_cnt_q + TotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_word_q      <= mem[addr_q];
      rd_valid_bit_q <= valid_q[addr_q];
      rd_idx_q       <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= glc_pkg::op_e'(operation_i);
      key_q     <= lookup_key_i;
      load_ok_q <= load_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      clock_q    <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.rd;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      if (cmd_i.load) begin
        addr_q <= '0;
        if (glc_pkg::op_e'(operation_i) == glc_pkg::OP_LOOKUP) begin
          clock_q <= clock_q + AgeW'(1);
        end
      end else if (cmd_i.rd) begin
        addr_q <= addr_q + IdxW'(1);
      end
      if (cmd_i.finish && (op_q == glc_pkg::OP_FLUSH)) begin
        valid_q <= '0;
        clock_q <= '0;
      end else if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
      hit_idx_q     <= '0;
      empty_idx_q   <= '0;
      old_idx_q     <= '0;
      oldest_q      <= '0;
    end else if (cmd_i.load) begin
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
      hit_idx_q     <= '0;
      empty_idx_q   <= '0;
      old_idx_q     <= '0;
      oldest_q      <= '0;
    end else if (rd_vld_q) begin
      if (!hit_found_q && (eff_key == key_q)) begin
        hit_found_q <= 1'b1;
        hit_idx_q   <= rd_idx_q;
      end
      if (!empty_found_q && (eff_key == '0)) begin
        empty_found_q <= 1'b1;
        empty_idx_q   <= rd_idx_q;
      end
      // >= so ties go to the later slot
      if (age_gap >= oldest_q) begin
        oldest_q  <= age_gap;
        old_idx_q <= rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_hit_tot_q  <= hit_cnt_d;
      out_miss_tot_q <= miss_cnt_d;
      if (op_q == glc_pkg::OP_FLUSH) begin
        out_hit_q   <= 1'b0;
        out_idx_q   <= '0;
        out_inst_q  <= 1'b0;
        out_blank_q <= 1'b0;
      end else if (hit_found_q) begin
        out_hit_q   <= 1'b1;
        out_idx_q   <= OutW'(hit_idx_q);
        out_inst_q  <= 1'b0;
        out_blank_q <= 1'b0;
      end else begin
        out_hit_q   <= 1'b0;
        out_idx_q   <= OutW'(victim);
        out_inst_q  <= load_ok_q;
        out_blank_q <= !load_ok_q;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.slot_index = out_idx_q;
  assign rsp_o.installed  = out_inst_q;
  assign rsp_o.blank      = out_blank_q;
  assign rsp_o.hit_total  = out_hit_tot_q;
  assign rsp_o.miss_total = out_miss_tot_q;

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (CntW'(addr_q) < n_act))
    else $error("slot read beyond active count");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd && mem_we))
    else $error("slot write during scan");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_hit_q, out_inst_q, out_blank_q}))
    else $error("more than one outcome flag set");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_fin |=> ((hit_cnt_q + miss_cnt_q) == ($past(hit_cnt_q + miss_cnt_q) + TotW'(1))))
    else $error("lookup did not bump exactly one counter");
`endif

endmodule
